### design/jse_pkg.sv
package jse_pkg;

    localparam int QDepth = 4;
    localparam int QAddrW = $clog2(QDepth);

    localparam logic [15:0] LIMIT_RESET = 16'd8192;

    localparam logic [1:0] REASON_END   = 2'd0;
    localparam logic [1:0] REASON_NUL   = 2'd1;
    localparam logic [1:0] REASON_UTF8  = 2'd2;
    localparam logic [1:0] REASON_LIMIT = 2'd3;

    typedef enum logic [1:0] {
        MODE_END,
        MODE_ESC,
        MODE_HEX,
        MODE_UTF8
    } t_mode;

    // one queued request: a character to expand, or a bare end marker
    typedef struct packed {
        t_mode       mode;
        logic [20:0] cp;
        logic [2:0]  nbytes;
        logic        eos;
        logic [1:0]  reason;
    } t_cmd;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h57 + {4'd0, v};
        end
        return r;
    endfunction

    // pick the output form and byte count of a decoded code point
    function automatic t_cmd classify(input logic [20:0] cp);
        t_cmd c;
        c.mode   = MODE_UTF8;
        c.cp     = cp;
        c.nbytes = 3'd1;
        c.eos    = 1'b0;
        c.reason = REASON_END;
        if (cp == 21'h22 || cp == 21'h5C) begin
            c.mode   = MODE_ESC;
            c.nbytes = 3'd2;
        end else if (cp == 21'h0A) begin
            c.mode   = MODE_ESC;
            c.cp     = 21'h6E;
            c.nbytes = 3'd2;
        end else if (cp == 21'h0D) begin
            c.mode   = MODE_ESC;
            c.cp     = 21'h72;
            c.nbytes = 3'd2;
        end else if (cp == 21'h09) begin
            c.mode   = MODE_ESC;
            c.cp     = 21'h74;
            c.nbytes = 3'd2;
        end else if (cp < 21'h20 || cp == 21'h7F) begin
            c.mode   = MODE_HEX;
            c.nbytes = 3'd6;
        end else if (cp < 21'h80) begin
            c.nbytes = 3'd1;
        end else if (cp < 21'h800) begin
            c.nbytes = 3'd2;
        end else if (cp < 21'h10000) begin
            c.nbytes = 3'd3;
        end else begin
            c.nbytes = 3'd4;
        end
        return c;
    endfunction

    // byte number idx of the expanded form of a request
    function automatic logic [7:0] emit_byte(input t_cmd c, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (c.mode)
            MODE_END: b = 8'h00;
            MODE_ESC: b = (idx == 3'd0) ? 8'h5C : c.cp[7:0];
            MODE_HEX: begin
                case (idx)
                    3'd0:    b = 8'h5C;
                    3'd1:    b = 8'h75;
                    3'd2:    b = 8'h30;
                    3'd3:    b = 8'h30;
                    3'd4:    b = hex_digit(c.cp[7:4]);
                    default: b = hex_digit(c.cp[3:0]);
                endcase
            end
            default: begin
                case (c.nbytes)
                    3'd1: b = c.cp[7:0];
                    3'd2: begin
                        b = (idx == 3'd0) ? {3'b110, c.cp[10:6]} : {2'b10, c.cp[5:0]};
                    end
                    3'd3: begin
                        case (idx)
                            3'd0:    b = {4'b1110, c.cp[15:12]};
                            3'd1:    b = {2'b10, c.cp[11:6]};
                            default: b = {2'b10, c.cp[5:0]};
                        endcase
                    end
                    default: begin
                        case (idx)
                            3'd0:    b = {5'b11110, c.cp[20:18]};
                            3'd1:    b = {2'b10, c.cp[17:12]};
                            3'd2:    b = {2'b10, c.cp[11:6]};
                            default: b = {2'b10, c.cp[5:0]};
                        endcase
                    end
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

### design/jse_front.sv
module jse_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [15:0]      i_cfg_out_limit,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_push,
    output jse_pkg::t_cmd    o_cmd
);

    logic [15:0] r_limit;
    logic [20:0] r_cp,    n_cp;
    logic [1:0]  r_pend,  n_pend;
    logic [2:0]  r_seq,   n_seq;
    logic [15:0] r_count, n_count;
    logic [1:0]  r_code,  n_code;
    logic        r_stopped, n_stopped;

    logic          complete;
    logic [20:0]   cp_done;
    logic [20:0]   acc;
    logic          bad;
    logic          halt;
    logic [1:0]    hcode;
    logic [2:0]    nbytes;
    jse_pkg::t_cmd cls;
    logic          near_one;
    logic          near_six;

    assign acc      = {r_cp[14:0], i_byte[5:0]};
    assign near_one = ({1'b0, r_count} + 17'd1) >= {1'b0, r_limit};
    assign near_six = ({1'b0, r_count} + 17'd6) >= {1'b0, r_limit};

    always_comb begin
        n_cp      = r_cp;
        n_pend    = r_pend;
        n_seq     = r_seq;
        n_count   = r_count;
        n_code    = r_code;
        n_stopped = r_stopped;
        complete  = 1'b0;
        cp_done   = '0;
        bad       = 1'b0;
        halt      = 1'b0;
        hcode     = jse_pkg::REASON_END;
        nbytes    = 3'd0;
        cls       = jse_pkg::classify(cp_done);

        if (!r_stopped) begin
            if (r_pend == 2'd0) begin
                if (i_byte == 8'h00) begin
                    halt  = 1'b1;
                    hcode = jse_pkg::REASON_NUL;
                end else if (near_one) begin
                    halt  = 1'b1;
                    hcode = jse_pkg::REASON_LIMIT;
                end else if (i_byte < 8'h80) begin
                    complete = 1'b1;
                    cp_done  = {13'd0, i_byte};
                end else if (i_byte >= 8'hC2 && i_byte <= 8'hDF) begin
                    n_cp   = {16'd0, i_byte[4:0]};
                    n_pend = 2'd1;
                    n_seq  = 3'd2;
                end else if (i_byte >= 8'hE0 && i_byte <= 8'hEF) begin
                    n_cp   = {17'd0, i_byte[3:0]};
                    n_pend = 2'd2;
                    n_seq  = 3'd3;
                end else if (i_byte >= 8'hF0 && i_byte <= 8'hF4) begin
                    n_cp   = {18'd0, i_byte[2:0]};
                    n_pend = 2'd3;
                    n_seq  = 3'd4;
                end else begin
                    halt  = 1'b1;
                    hcode = jse_pkg::REASON_UTF8;
                end
            end else if (i_byte[7:6] != 2'b10) begin
                halt  = 1'b1;
                hcode = jse_pkg::REASON_UTF8;
            end else begin
                n_cp   = acc;
                n_pend = r_pend - 2'd1;
                if (r_pend == 2'd1) begin
                    if (r_seq == 3'd3) begin
                        bad = acc < 21'h800 || (acc >= 21'hD800 && acc <= 21'hDFFF);
                    end else if (r_seq == 3'd4) begin
                        bad = acc < 21'h10000 || acc > 21'h10FFFF;
                    end
                    n_seq = 3'd0;
                    n_cp  = '0;
                    if (bad) begin
                        halt  = 1'b1;
                        hcode = jse_pkg::REASON_UTF8;
                    end else begin
                        complete = 1'b1;
                        cp_done  = acc;
                    end
                end
            end

            cls = jse_pkg::classify(cp_done);
            if (complete) begin
                if (near_six) begin
                    halt  = 1'b1;
                    hcode = jse_pkg::REASON_LIMIT;
                end else begin
                    nbytes  = cls.nbytes;
                    n_count = r_count + {13'd0, cls.nbytes};
                end
            end

            // a string that ends mid-character is invalid
            if (i_last && !halt) begin
                halt  = 1'b1;
                hcode = (n_pend != 2'd0) ? jse_pkg::REASON_UTF8 : jse_pkg::REASON_END;
            end

            if (halt) begin
                n_stopped = 1'b1;
                n_code    = hcode;
                n_pend    = 2'd0;
                n_seq     = 3'd0;
                n_cp      = '0;
            end
        end

        o_cmd        = cls;
        o_cmd.eos    = i_last;
        o_cmd.reason = i_last ? n_code : jse_pkg::REASON_END;
        if (nbytes == 3'd0) begin
            o_cmd.mode   = jse_pkg::MODE_END;
            o_cmd.nbytes = 3'd1;
        end

        // start the next string from scratch
        if (i_last) begin
            n_cp      = '0;
            n_pend    = 2'd0;
            n_seq     = 3'd0;
            n_count   = '0;
            n_code    = jse_pkg::REASON_END;
            n_stopped = 1'b0;
        end
    end

    assign o_push = i_accept && (i_last || nbytes != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= jse_pkg::LIMIT_RESET;
            r_cp      <= '0;
            r_pend    <= 2'd0;
            r_seq     <= 3'd0;
            r_count   <= '0;
            r_code    <= jse_pkg::REASON_END;
            r_stopped <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_out_limit;
            end
            if (i_accept) begin
                r_cp      <= n_cp;
                r_pend    <= n_pend;
                r_seq     <= n_seq;
                r_count   <= n_count;
                r_code    <= n_code;
                r_stopped <= n_stopped;
            end
        end
    end

endmodule

### design/jse_fifo.sv
module jse_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jse_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output jse_pkg::t_cmd    o_head
);

    jse_pkg::t_cmd                r_mem [jse_pkg::QDepth];
    logic [jse_pkg::QAddrW-1:0]   r_wp;
    logic [jse_pkg::QAddrW-1:0]   r_rp;
    logic [jse_pkg::QAddrW:0]     r_cnt;

    assign o_full     = r_cnt == (jse_pkg::QAddrW + 1)'(jse_pkg::QDepth);
    assign o_nonempty = r_cnt != '0;
    assign o_head     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### design/jse_back.sv
module jse_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  jse_pkg::t_cmd    i_head,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_end_of_string,
    output logic [1:0]       o_stop_reason
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_bvalid;
    logic       r_eos;
    logic [1:0] r_reason;
    logic       advance;
    logic       at_end;

    assign advance = i_head_valid && (!r_valid || !i_out_stall);
    assign at_end  = r_idx == (i_head.nbytes - 3'd1);
    assign o_pop   = advance && at_end;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte   <= jse_pkg::emit_byte(i_head, r_idx);
            r_bvalid <= i_head.mode != jse_pkg::MODE_END;
            r_eos    <= i_head.eos && at_end;
            r_reason <= (i_head.eos && at_end) ? i_head.reason : jse_pkg::REASON_END;
        end
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 3'd0 : r_idx + 3'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_valid;
    assign o_out_byte      = r_byte;
    assign o_byte_valid    = r_bvalid;
    assign o_end_of_string = r_eos;
    assign o_stop_reason   = r_reason;

endmodule

### design/json_string_escaper_core.sv
// The first output byte of a character passes the request queue, then the output register,
//   once its last input byte is accepted.
// Throughput: one input byte per cycle while each yields at most one output byte and the
//   queue is not full; the output register sends one byte per cycle when not stalled, and
//   the four-entry request queue absorbs the difference when a character, such as a six-byte escape, yields more.
// Reset (i_rst_n low, synchronous): clears string state, queue and output, out_limit = 8192.
module json_string_escaper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_out_limit,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_end_of_string,
    output logic [1:0]  o_stop_reason
);

    logic          full;
    logic          push;
    logic          pop;
    logic          head_valid;
    logic          accept;
    jse_pkg::t_cmd cmd;
    jse_pkg::t_cmd head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    jse_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_out_limit (i_cfg_out_limit),
        .i_accept        (accept),
        .i_byte          (i_in_byte),
        .i_last          (i_in_last),
        .o_push          (push),
        .o_cmd           (cmd)
    );

    jse_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (cmd),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (head_valid),
        .o_head     (head)
    );

    jse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_stop_reason   (o_stop_reason)
    );

endmodule

### design/jse_checker.sv
module jse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_end_of_string,
    input logic [1:0] o_stop_reason
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_end_of_string) && $stable(o_stop_reason))
        else $error("stalled output changed");

    a_reason_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_end_of_string |-> o_stop_reason == 2'd0)
        else $error("stop reason on a non-final result");

    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_end_of_string && o_out_byte == 8'h00)
        else $error("bare result is not an end marker");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_byte      (o_out_byte),
    .o_byte_valid    (o_byte_valid),
    .o_end_of_string (o_end_of_string),
    .o_stop_reason   (o_stop_reason)
);

### test/tb_json_string_escaper_core.sv
module tb_json_string_escaper_core;

    localparam int HoldCycles  = 150;
    localparam int DrainCycles = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       eos;
        logic [1:0] reason;
    } t_esc_result;

    class escape_scoreboard;
        logic [15:0] out_limit;
        logic [20:0] partial_cp;
        logic [1:0]  cont_left;
        logic [2:0]  seq_len;
        logic [15:0] out_count;
        logic [1:0]  stop_code;
        bit          stopped;
        t_esc_result expected_bytes[$];

        function new();
            out_limit = jse_pkg::LIMIT_RESET;
            clear_string();
        endfunction

        function void clear_string();
            partial_cp = '0;
            cont_left  = '0;
            seq_len    = '0;
            out_count  = '0;
            stop_code  = jse_pkg::REASON_END;
            stopped    = 1'b0;
        endfunction

        function void halt(input logic [1:0] code);
            stopped    = 1'b1;
            stop_code  = code;
            cont_left  = '0;
            seq_len    = '0;
            partial_cp = '0;
        endfunction

        function void put_byte(input logic [7:0] b);
            t_esc_result r;
            r.data     = b;
            r.has_data = 1'b1;
            r.eos      = 1'b0;
            r.reason   = jse_pkg::REASON_END;
            expected_bytes.push_back(r);
            out_count  = out_count + 16'd1;
        endfunction

        function logic [7:0] nibble_char(input logic [3:0] v);
            return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h61 + {4'd0, v} - 8'd10;
        endfunction

        function void expand(input logic [20:0] cp);
            case (cp)
                21'h22:  begin put_byte(8'h5C); put_byte(8'h22); end
                21'h5C:  begin put_byte(8'h5C); put_byte(8'h5C); end
                21'h0A:  begin put_byte(8'h5C); put_byte(8'h6E); end
                21'h0D:  begin put_byte(8'h5C); put_byte(8'h72); end
                21'h09:  begin put_byte(8'h5C); put_byte(8'h74); end
                default: begin
                    if (cp < 21'h20 || cp == 21'h7F) begin
                        put_byte(8'h5C);
                        put_byte(8'h75);
                        put_byte(8'h30);
                        put_byte(8'h30);
                        put_byte(nibble_char(cp[7:4]));
                        put_byte(nibble_char(cp[3:0]));
                    end else if (cp < 21'h80) begin
                        put_byte(cp[7:0]);
                    end else if (cp < 21'h800) begin
                        put_byte({3'b110, cp[10:6]});
                        put_byte({2'b10, cp[5:0]});
                    end else if (cp < 21'h10000) begin
                        put_byte({4'b1110, cp[15:12]});
                        put_byte({2'b10, cp[11:6]});
                        put_byte({2'b10, cp[5:0]});
                    end else begin
                        put_byte({5'b11110, cp[20:18]});
                        put_byte({2'b10, cp[17:12]});
                        put_byte({2'b10, cp[11:6]});
                        put_byte({2'b10, cp[5:0]});
                    end
                end
            endcase
        endfunction

        // predict the bytes that one accepted request produces
        function void note_request(input logic [7:0] b, input logic is_last);
            logic [20:0] cp;
            bit          done;
            bit          bad;
            int          start_idx;
            t_esc_result marker;
            start_idx = expected_bytes.size();
            cp        = '0;
            done      = 1'b0;
            if (!stopped) begin
                if (cont_left == 2'd0) begin
                    if (b == 8'h00) begin
                        halt(jse_pkg::REASON_NUL);
                    end else if (int'(out_count) + 1 >= int'(out_limit)) begin
                        halt(jse_pkg::REASON_LIMIT);
                    end else if (b < 8'h80) begin
                        cp   = {13'd0, b};
                        done = 1'b1;
                    end else if (b >= 8'hC2 && b <= 8'hDF) begin
                        partial_cp = {16'd0, b[4:0]};
                        cont_left  = 2'd1;
                        seq_len    = 3'd2;
                    end else if (b >= 8'hE0 && b <= 8'hEF) begin
                        partial_cp = {17'd0, b[3:0]};
                        cont_left  = 2'd2;
                        seq_len    = 3'd3;
                    end else if (b >= 8'hF0 && b <= 8'hF4) begin
                        partial_cp = {18'd0, b[2:0]};
                        cont_left  = 2'd3;
                        seq_len    = 3'd4;
                    end else begin
                        halt(jse_pkg::REASON_UTF8);
                    end
                end else if (b[7:6] != 2'b10) begin
                    halt(jse_pkg::REASON_UTF8);
                end else begin
                    partial_cp = {partial_cp[14:0], b[5:0]};
                    cont_left  = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        cp  = partial_cp;
                        bad = (seq_len == 3'd3 &&
                               (cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF))) ||
                              (seq_len == 3'd4 && (cp < 21'h10000 || cp > 21'h10FFFF));
                        seq_len    = '0;
                        partial_cp = '0;
                        if (bad) begin
                            halt(jse_pkg::REASON_UTF8);
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                if (done) begin
                    if (int'(out_count) + 6 >= int'(out_limit)) begin
                        halt(jse_pkg::REASON_LIMIT);
                    end else begin
                        expand(cp);
                    end
                end
                if (is_last && !stopped) begin
                    halt((cont_left != 2'd0) ? jse_pkg::REASON_UTF8 : jse_pkg::REASON_END);
                end
            end
            if (is_last) begin
                // the end flag rides on the last byte, or on a bare marker
                if (expected_bytes.size() == start_idx) begin
                    marker = '0;
                    expected_bytes.push_back(marker);
                end
                expected_bytes[expected_bytes.size() - 1].eos    = 1'b1;
                expected_bytes[expected_bytes.size() - 1].reason = stop_code;
                clear_string();
            end
        endfunction

        function bit check_result(input t_esc_result got, output string why);
            t_esc_result want;
            why = "";
            if (expected_bytes.size() == 0) begin
                why = $sformatf("unexpected byte=%02h bv=%0b eos=%0b reason=%0d",
                                got.data, got.has_data, got.eos, got.reason);
                return 1'b0;
            end
            want = expected_bytes.pop_front();
            if (got.data !== want.data || got.has_data !== want.has_data ||
                got.eos !== want.eos || got.reason !== want.reason) begin
                why = $sformatf("got byte=%02h bv=%0b eos=%0b reason=%0d, want %02h %0b %0b %0d",
                                got.data, got.has_data, got.eos, got.reason,
                                want.data, want.has_data, want.eos, want.reason);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function int waiting();
            return expected_bytes.size();
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [15:0] i_cfg_out_limit = 16'd0;
    logic        i_in_valid      = 1'b0;
    logic [7:0]  i_in_byte       = 8'd0;
    logic        i_in_last       = 1'b0;
    logic        i_out_stall     = 1'b0;
    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_end_of_string;
    logic [1:0]  o_stop_reason;

    escape_scoreboard sb = new();

    int         mismatches    = 0;
    int         items_sent    = 0;
    int         idle_pct      = 0;
    int         stall_pct     = 0;
    int         hold_requests = 0;
    int         hold_seen     = 0;
    int         hold_left     = 0;
    string      why;
    logic [7:0] str_bytes[$];

    json_string_escaper_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_out_limit (i_cfg_out_limit),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_in_last       (i_in_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_stop_reason   (o_stop_reason)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 100) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_seen != hold_requests) begin
            i_out_stall <= 1'b1;
            hold_seen   <= hold_requests;
            hold_left   <= HoldCycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (!sb.check_result({o_out_byte, o_byte_valid, o_end_of_string, o_stop_reason},
                                 why)) begin
                report_mismatch(why);
            end
        end
    end

    function automatic logic [7:0] cont_byte();
        logic [7:0] b;
        b = 8'($urandom_range(8'hBF, 8'h80));
        return b;
    endfunction

    function automatic void push_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            str_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            str_bytes.push_back({3'b110, cp[10:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            str_bytes.push_back({4'b1110, cp[15:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            str_bytes.push_back({5'b11110, cp[20:18]});
            str_bytes.push_back({2'b10, cp[17:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void add_char();
        logic [20:0] cp;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0:       cp = 21'h22;
                    1:       cp = 21'h5C;
                    2:       cp = 21'h0A;
                    3:       cp = 21'h0D;
                    default: cp = 21'h09;
                endcase
            end
            1:       cp = ($urandom_range(3) == 0) ? 21'h7F : 21'($urandom_range(31, 1));
            2, 3, 4: cp = 21'($urandom_range(126, 32));
            5, 6:    cp = 21'($urandom_range(21'h7FF, 21'h80));
            7: begin
                cp = 21'($urandom_range(21'hFFFF, 21'h800));
                // move out of the surrogate range
                if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
                    cp = cp ^ 21'h2000;
                end
            end
            8:       cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            default: begin
                case ($urandom_range(7))
                    0:       cp = 21'h80;
                    1:       cp = 21'h7FF;
                    2:       cp = 21'h800;
                    3:       cp = 21'hD7FF;
                    4:       cp = 21'hE000;
                    5:       cp = 21'hFFFF;
                    6:       cp = 21'h10000;
                    default: cp = 21'h10FFFF;
                endcase
            end
        endcase
        push_utf8(cp);
    endfunction

    function automatic void add_broken();
        logic [7:0] b;
        case ($urandom_range(7))
            0: begin
                b = 8'($urandom_range(8'hC1, 8'h80));
                str_bytes.push_back(b);
            end
            1: begin
                b = 8'($urandom_range(8'hFF, 8'hF5));
                str_bytes.push_back(b);
            end
            2: begin
                // lead byte followed by something that is not a continuation
                b = 8'($urandom_range(8'hF4, 8'hC2));
                str_bytes.push_back(b);
                b = 8'($urandom_range(8'h7F, 8'h01));
                str_bytes.push_back(b);
            end
            3: begin
                b = 8'($urandom_range(8'h9F, 8'h80));
                str_bytes.push_back(8'hE0);
                str_bytes.push_back(b);
                str_bytes.push_back(cont_byte());
            end
            4: begin
                b = 8'($urandom_range(8'hBF, 8'hA0));
                str_bytes.push_back(8'hED);
                str_bytes.push_back(b);
                str_bytes.push_back(cont_byte());
            end
            5: begin
                b = 8'($urandom_range(8'hBF, 8'h90));
                str_bytes.push_back(8'hF4);
                str_bytes.push_back(b);
                str_bytes.push_back(cont_byte());
                str_bytes.push_back(cont_byte());
            end
            6: begin
                b = 8'($urandom_range(8'h8F, 8'h80));
                str_bytes.push_back(8'hF0);
                str_bytes.push_back(b);
                str_bytes.push_back(cont_byte());
                str_bytes.push_back(cont_byte());
            end
            default: str_bytes.push_back(8'h00);
        endcase
    endfunction

    function automatic void make_string();
        int         n_chars;
        int         pick;
        int         needs;
        logic [7:0] b;
        str_bytes.delete();
        n_chars = $urandom_range(10, 1);
        for (int i = 0; i < n_chars; i++) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                add_char();
            end else if (pick < 90) begin
                add_broken();
            end else begin
                b = 8'($urandom_range(255));
                str_bytes.push_back(b);
            end
        end
        // end some strings in the middle of a sequence
        if ($urandom_range(9) == 0) begin
            b = 8'($urandom_range(8'hF4, 8'hC2));
            str_bytes.push_back(b);
            needs = (b >= 8'hF0) ? 3 : (b >= 8'hE0) ? 2 : 1;
            for (int i = $urandom_range(needs - 1); i > 0; i--) begin
                str_bytes.push_back(cont_byte());
            end
        end
    endfunction

    task automatic send_request(input logic [7:0] b, input logic is_last);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= is_last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_request(b, is_last);
        items_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++) begin
            send_request(str_bytes[i], i == str_bytes.size() - 1);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.waiting() != 0) begin
            @(posedge i_clk);
        end
        // ignored bytes may still be in flight
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        i_cfg_valid     <= 1'b1;
        i_cfg_out_limit <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        sb.out_limit = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] v, input int idle, input int stall,
                             input int n, input bit hold);
        int stop_at;
        write_limit(v);
        idle_pct  = idle;
        stall_pct = stall;
        if (hold) begin
            hold_requests <= hold_requests + 1;
        end
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            make_string();
            send_string();
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // escapes, hex escapes and plain ASCII
        str_bytes = '{8'h41, 8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h09, 8'h01, 8'h1F, 8'h7F};
        send_string();
        // smallest two-byte and largest four-byte characters
        str_bytes = '{8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // surrogate, then a byte ignored until the end marker
        str_bytes = '{8'hED, 8'hA0, 8'h80, 8'h41};
        send_string();
        str_bytes = '{8'h00};
        send_string();
        str_bytes = '{8'hFF};
        send_string();
        // truncated final sequence
        str_bytes = '{8'hE2, 8'h82};
        send_string();
        wait_drained();

        run_phase(16'hFFFF, 0, 0, 45, 1'b0);
        run_phase(16'd20, 65, 0, 45, 1'b0);
        run_phase(16'd8, 0, 65, 45, 1'b0);
        run_phase(16'd3, 22, 22, 20, 1'b0);
        run_phase(16'd0, 22, 22, 12, 1'b0);
        run_phase(16'd300, 0, 0, 45, 1'b1);
        run_phase(16'd8192, 22, 22, 50, 1'b0);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
design/jse_pkg.sv
design/jse_front.sv
design/jse_fifo.sv
design/jse_back.sv
design/json_string_escaper_core.sv
design/jse_checker.sv
test/tb_json_string_escaper_core.sv
